// File: sv/rational_fraction_reducer_defines.svh
// Assertion macros shared by the reducer RTL.
// With SYNTH defined the macros expand to nothing.
`ifndef RATIONAL_FRACTION_REDUCER_DEFINES_SVH
`define RATIONAL_FRACTION_REDUCER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define RFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfr assertion failed");

`else

`define RFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RFR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/rfr_pkg.sv
`timescale 1ns / 1ps

package rfr_pkg;

    // Result classes
    localparam logic [1:0] KIND_ZERO  = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_RATIO = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV_NUM,
        ST_DEN_INIT,
        ST_DIV_DEN,
        ST_FINISH
    } rfr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;          // capture operands, start gcd
        logic gcd_step;      // one binary gcd step
        logic gcd_finish;    // form divisor from gcd registers
        logic div_init_num;  // start numerator division
        logic div_init_den;  // save numerator quotient, start denominator division
        logic div_step;      // one restoring division bit
        logic out_load;      // load output register
    } rfr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic nu_zero;       // numerator magnitude is zero
        logic gcd_done;      // one gcd operand reached zero
        logic div_last;      // current division step is the last
    } rfr_status_t;

endpackage

// File: sv/rfr_ctrl.sv
`timescale 1ns / 1ps
`include "rational_fraction_reducer_defines.svh"

module rfr_ctrl
    import rfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rfr_status_t status,
    output rfr_cmd_t    cmd
);

    rfr_state_t state_reg;
    rfr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (status.nu_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.gcd_done)
                begin
                    cmd.gcd_finish   = 1'b1;
                    cmd.div_init_num = 1'b1;
                    state_next       = ST_DIV_NUM;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_NUM:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DEN_INIT;
                end
            end
            ST_DEN_INIT:
            begin
                cmd.div_init_den = 1'b1;
                state_next       = ST_DIV_DEN;
            end
            ST_DIV_DEN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output transaction pending flag
    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    assign out_valid      = out_valid_reg;

    // Checks
    `RFR_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    `RFR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `RFR_ASSERT_IMP(a_one_unit, clk, rst_n, cmd.gcd_step, !cmd.div_step && !cmd.out_load)

endmodule

// File: sv/rfr_datapath.sv
`timescale 1ns / 1ps
`include "rational_fraction_reducer_defines.svh"

module rfr_datapath
    import rfr_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] numerator_in,
    input  logic [VALUE_BITS-1:0] denominator_in,
    input  rfr_cmd_t              cmd,
    output rfr_status_t           status,
    output logic [1:0]            result_kind,
    output logic                  result_negative,
    output logic [VALUE_BITS-1:0] numerator_magnitude,
    output logic [VALUE_BITS-1:0] denominator_out
);

    localparam int KW = $clog2(VALUE_BITS);
    localparam int VB = VALUE_BITS;

    logic [VB-1:0] num_mag;
    logic [VB-1:0] den_mag;

    logic [VB-1:0] nu_reg,   nu_next;
    logic [VB-1:0] de_reg,   de_next;
    logic          neg_reg,  neg_next;
    logic          nz_reg,   nz_next;
    logic [VB-1:0] a_reg,    a_next;
    logic [VB-1:0] b_reg,    b_next;
    logic [KW-1:0] k_reg,    k_next;
    logic [VB-1:0] g_reg,    g_next;
    logic [VB-1:0] rem_reg,  rem_next;
    logic [VB-1:0] quo_reg,  quo_next;
    logic [VB-1:0] nq_reg,   nq_next;
    logic [KW-1:0] cnt_reg,  cnt_next;

    logic [1:0]    kind_reg, kind_next;
    logic          oneg_reg, oneg_next;
    logic [VB-1:0] onum_reg, onum_next;
    logic [VB-1:0] oden_reg, oden_next;

    logic [VB:0]   shifted;
    logic [VB:0]   diff;

    // Operand magnitudes (most negative value maps to 2^(VB-1))
    assign num_mag = numerator_in[VB-1]   ? (~numerator_in + VB'(1))   : numerator_in;
    assign den_mag = denominator_in[VB-1] ? (~denominator_in + VB'(1)) : denominator_in;

    // Restoring divider step: remainder below the divisor, so no overflow
    assign shifted = {rem_reg, quo_reg[VB-1]};
    assign diff    = shifted - {1'b0, g_reg};

    // Next-state logic
    always_comb
    begin
        nu_next   = nu_reg;
        de_next   = de_reg;
        neg_next  = neg_reg;
        nz_next   = nz_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        nq_next   = nq_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        oneg_next = oneg_reg;
        onum_next = onum_reg;
        oden_next = oden_reg;

        // operand capture
        if (cmd.load)
        begin
            nu_next  = num_mag;
            de_next  = den_mag;
            neg_next = numerator_in[VB-1] ^ denominator_in[VB-1];
            nz_next  = (num_mag == '0);
            a_next   = den_mag;
            b_next   = num_mag;
            k_next   = '0;
        end

        // binary gcd step
        if (cmd.gcd_step)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end

        // divisor from odd part and common power of two
        if (cmd.gcd_finish)
        begin
            g_next = (a_reg | b_reg) << k_reg;
        end

        // division set-up
        if (cmd.div_init_num)
        begin
            rem_next = '0;
            quo_next = nu_reg;
            cnt_next = '0;
        end
        if (cmd.div_init_den)
        begin
            nq_next  = quo_reg;
            rem_next = '0;
            quo_next = de_reg;
            cnt_next = '0;
        end

        // one quotient bit
        if (cmd.div_step)
        begin
            if (!diff[VB])
            begin
                rem_next = diff[VB-1:0];
            end
            else
            begin
                rem_next = shifted[VB-1:0];
            end
            quo_next = {quo_reg[VB-2:0], ~diff[VB]};
            cnt_next = cnt_reg + KW'(1);
        end

        // output register
        if (cmd.out_load)
        begin
            if (nz_reg)
            begin
                kind_next = KIND_ZERO;
                oneg_next = 1'b0;
                onum_next = '0;
                oden_next = VB'(1);
            end
            else
            begin
                kind_next = (quo_reg == VB'(1)) ? KIND_INT : KIND_RATIO;
                oneg_next = neg_reg;
                onum_next = nq_reg;
                oden_next = quo_reg;
            end
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        nu_reg   <= nu_next;
        de_reg   <= de_next;
        neg_reg  <= neg_next;
        nz_reg   <= nz_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        nq_reg   <= nq_next;
        kind_reg <= kind_next;
        oneg_reg <= oneg_next;
        onum_reg <= onum_next;
        oden_reg <= oden_next;
    end

    // Status and outputs
    assign status.nu_zero  = nz_reg;
    assign status.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign status.div_last = (cnt_reg == KW'(VB - 1));

    assign result_kind         = kind_reg;
    assign result_negative     = oneg_reg;
    assign numerator_magnitude = onum_reg;
    assign denominator_out     = oden_reg;

    // Checks: the gcd divides both magnitudes exactly and is nonzero while dividing
    `RFR_ASSERT_IMP(a_num_exact, clk, rst_n, cmd.div_init_den, rem_reg == '0)
    `RFR_ASSERT_IMP(a_den_exact, clk, rst_n, cmd.out_load && !nz_reg, rem_reg == '0)
    `RFR_ASSERT_IMP(a_div_nonzero, clk, rst_n, cmd.div_step, g_reg != '0)

endmodule

// File: sv/rational_fraction_reducer.sv
// A zero numerator goes straight to the output register; else the block runs the binary gcd
// (at most 2*VALUE_BITS-1 steps), then divides the numerator and the denominator by the gcd.
// One transaction in flight; the next can be taken from the cycle after the result is loaded.
// A new item is taken while a result waits in the output register. Reset (rst_n, async,
// active low) clears the controller and output valid; payload registers are not reset.
`timescale 1ns / 1ps

module rational_fraction_reducer
    import rfr_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] numerator_in,
    input  logic [VALUE_BITS-1:0] denominator_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            result_kind,
    output logic                  result_negative,
    output logic [VALUE_BITS-1:0] numerator_magnitude,
    output logic [VALUE_BITS-1:0] denominator_out
);

    rfr_cmd_t    cmd;
    rfr_status_t status;

    // Sequencer
    rfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // GCD, divider and output register
    rfr_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .numerator_in        (numerator_in),
        .denominator_in      (denominator_in),
        .cmd                 (cmd),
        .status              (status),
        .result_kind         (result_kind),
        .result_negative     (result_negative),
        .numerator_magnitude (numerator_magnitude),
        .denominator_out     (denominator_out)
    );

endmodule

// File: verif/tb_rational_fraction_reducer.sv
`timescale 1ns / 1ps

module tb_rational_fraction_reducer
    import rfr_pkg::*;
();

    localparam int VB              = 32;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AT     = 300;
    localparam int RANDOM_ITEMS    = 750;

    localparam logic [VB-1:0] MIN_VAL = {1'b1, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] MAX_VAL = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] ONE     = 1;
    localparam logic [VB-1:0] NEG_ONE = '1;

    // Reduced fraction as the block presents it
    typedef struct packed {
        logic [1:0]    kind;
        logic          negative;
        logic [VB-1:0] num_mag;
        logic [VB-1:0] den_mag;
    } fraction_t;

    // One row of the directed table; fixed_exp set where the answer is typed in
    typedef struct {
        logic [VB-1:0] num;
        logic [VB-1:0] den;
        bit            fixed_exp;
        fraction_t     answer;
    } fraction_row_t;

    // Sender side record of an offered operand pair
    typedef struct {
        bit        fixed_exp;
        fraction_t answer;
    } offer_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [VB-1:0] numerator_in;
    logic [VB-1:0] denominator_in;
    logic          out_valid;
    logic          out_ready;
    logic [1:0]    result_kind;
    logic          result_negative;
    logic [VB-1:0] numerator_magnitude;
    logic [VB-1:0] denominator_out;

    fraction_row_t directed_rows[$];
    offer_t        offered_q[$];
    fraction_t     reduced_q[$];
    int            error_count;
    int            result_count;
    int            cycle_count;

    rational_fraction_reducer #(
        .VALUE_BITS(VB)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .numerator_in        (numerator_in),
        .denominator_in      (denominator_in),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_kind         (result_kind),
        .result_negative     (result_negative),
        .numerator_magnitude (numerator_magnitude),
        .denominator_out     (denominator_out)
    );

    // Clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lowest terms by Euclid's remainder loop, sign carried on the numerator
    function automatic fraction_t reduce_fraction(input logic [VB-1:0] num,
                                                  input logic [VB-1:0] den);
        logic [VB-1:0] num_mag;
        logic [VB-1:0] den_mag;
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        logic [VB-1:0] r;
        fraction_t     res;
        num_mag = num[VB-1] ? -num : num;
        den_mag = den[VB-1] ? -den : den;
        if (num_mag == '0)
        begin
            res.kind     = KIND_ZERO;
            res.negative = 1'b0;
            res.num_mag  = '0;
            res.den_mag  = ONE;
            return res;
        end
        a = den_mag;
        b = num_mag;
        r = a % b;
        while (r != '0)
        begin
            a = b;
            b = r;
            r = a % b;
        end
        res.num_mag  = num_mag / b;
        res.den_mag  = den_mag / b;
        res.kind     = (res.den_mag == ONE) ? KIND_INT : KIND_RATIO;
        res.negative = num[VB-1] ^ den[VB-1];
        return res;
    endfunction

    function automatic fraction_row_t make_row(input logic [VB-1:0] num,
                                               input logic [VB-1:0] den,
                                               input bit fixed_exp,
                                               input logic [1:0] kind,
                                               input logic negative,
                                               input logic [VB-1:0] num_mag,
                                               input logic [VB-1:0] den_mag);
        fraction_row_t row;
        row.num              = num;
        row.den              = den;
        row.fixed_exp        = fixed_exp;
        row.answer.kind      = kind;
        row.answer.negative  = negative;
        row.answer.num_mag   = num_mag;
        row.answer.den_mag   = den_mag;
        return row;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VB-1:0] random_sign(input logic [VB-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [VB-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ONE;
            2: return NEG_ONE;
            3: return MIN_VAL;
            4: return MAX_VAL;
            default: return MIN_VAL + ONE;
        endcase
    endfunction

    // Random operand pair, weighted towards shared factors and exact quotients
    task automatic pick_operands(output logic [VB-1:0] num, output logic [VB-1:0] den);
        int unsigned   r;
        logic [VB-1:0] g;
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            g   = $urandom_range(1, 4000);
            a   = $urandom_range(0, 500000);
            b   = $urandom_range(1, 500000);
            num = random_sign(g * a);
            den = random_sign(g * b);
        end
        else if (r < 55)
        begin
            num = $urandom;
            den = $urandom;
        end
        else if (r < 65)
        begin
            a = $urandom_range(1, 50000);
            b = $urandom_range(1, 40000);
            if ($urandom_range(0, 1))
            begin
                num = random_sign(a * b);
                den = random_sign(a);
            end
            else
            begin
                num = random_sign(a);
                den = random_sign(a * b);
            end
        end
        else if (r < 75)
        begin
            num = $urandom_range(0, 2) == 0 ? $urandom : pick_extreme();
            den = $urandom_range(0, 2) == 0 ? $urandom : pick_extreme();
        end
        else if (r < 82)
        begin
            if ($urandom_range(0, 1))
            begin
                num = '0;
                den = $urandom;
            end
            else
            begin
                num = $urandom;
                den = '0;
            end
        end
        else if (r < 90)
        begin
            num = random_sign(ONE << $urandom_range(0, VB-1));
            den = random_sign(ONE << $urandom_range(0, VB-1));
        end
        else
        begin
            g   = $urandom_range(1, 65535);
            num = random_sign(g * $urandom_range(1, 32767));
            den = random_sign($urandom);
        end
    endtask

    // One transaction on the input side; entered and left at a falling edge
    task automatic offer_fraction(input logic [VB-1:0] num, input logic [VB-1:0] den,
                                  input bit fixed_exp, input fraction_t answer,
                                  inout int unsigned steady_left);
        int unsigned gap;
        offer_t      o;
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
                steady_left = $urandom_range(10, 40);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        o.fixed_exp = fixed_exp;
        o.answer    = answer;
        offered_q.push_back(o);
        in_valid       = 1'b1;
        numerator_in   = num;
        denominator_in = den;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [VB-1:0] expected,
                               input logic [VB-1:0] actual);
        if (expected !== actual)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d (0x%0h) actual %0d (0x%0h)",
                     $time, name, expected, expected, actual, actual);
        end
    endtask

    // Predict on each input transaction, check on each output transaction
    always @(posedge clk)
    begin
        offer_t    o;
        fraction_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb_rational_fraction_reducer failed");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            o = offered_q.pop_front();
            if (o.fixed_exp)
                reduced_q.push_back(o.answer);
            else
                reduced_q.push_back(reduce_fraction(numerator_in, denominator_in));
        end
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (reduced_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing outstanding, kind %0d num %0d den %0d",
                         $time, result_kind, numerator_magnitude, denominator_out);
            end
            else
            begin
                want = reduced_q.pop_front();
                check_field("result_kind", VB'(want.kind), VB'(result_kind));
                check_field("result_negative", VB'(want.negative), VB'(result_negative));
                check_field("numerator_magnitude", want.num_mag, numerator_magnitude);
                check_field("denominator_out", want.den_mag, denominator_out);
            end
        end
    end

    // Receiver: random stalls, steady stretches, and one long hold-off to back up the block
    initial
    begin
        int unsigned gap;
        int unsigned steady_left;
        bit          held_off;
        steady_left = 0;
        held_off    = 1'b0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && result_count >= HOLD_OFF_AT)
            begin
                held_off  = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (steady_left > 0)
            begin
                steady_left--;
                gap = 0;
            end
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    steady_left = $urandom_range(20, 80);
                gap = pick_gap();
            end
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Sender and end of run
    initial
    begin
        logic [VB-1:0] num;
        logic [VB-1:0] den;
        fraction_t     unused;
        int unsigned   steady_left;
        error_count    = 0;
        result_count   = 0;
        cycle_count    = 0;
        steady_left    = 0;
        unused         = '0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        numerator_in   = '0;
        denominator_in = '0;

        // Directed table: zero numerator, zero denominator, extremes, sign handling
        directed_rows.push_back(make_row(0, 5, 1'b1, KIND_ZERO, 1'b0, 0, 1));
        directed_rows.push_back(make_row(0, 0, 1'b1, KIND_ZERO, 1'b0, 0, 1));
        directed_rows.push_back(make_row(0, MIN_VAL, 1'b1, KIND_ZERO, 1'b0, 0, 1));
        directed_rows.push_back(make_row(0, NEG_ONE, 1'b1, KIND_ZERO, 1'b0, 0, 1));
        directed_rows.push_back(make_row(7, 0, 1'b1, KIND_RATIO, 1'b0, 1, 0));
        directed_rows.push_back(make_row(-7, 0, 1'b1, KIND_RATIO, 1'b1, 1, 0));
        directed_rows.push_back(make_row(MIN_VAL, 0, 1'b1, KIND_RATIO, 1'b1, 1, 0));
        directed_rows.push_back(make_row(MIN_VAL, NEG_ONE, 1'b1, KIND_INT, 1'b0, MIN_VAL, 1));
        directed_rows.push_back(make_row(MIN_VAL, ONE, 1'b1, KIND_INT, 1'b1, MIN_VAL, 1));
        directed_rows.push_back(make_row(MAX_VAL, ONE, 1'b1, KIND_INT, 1'b0, MAX_VAL, 1));
        directed_rows.push_back(make_row(MAX_VAL, NEG_ONE, 1'b1, KIND_INT, 1'b1, MAX_VAL, 1));
        directed_rows.push_back(make_row(ONE, MIN_VAL, 1'b1, KIND_RATIO, 1'b1, 1, MIN_VAL));
        directed_rows.push_back(make_row(NEG_ONE, MIN_VAL, 1'b1, KIND_RATIO, 1'b0, 1, MIN_VAL));
        directed_rows.push_back(make_row(MIN_VAL, MIN_VAL, 1'b1, KIND_INT, 1'b0, 1, 1));
        directed_rows.push_back(make_row(MAX_VAL, MAX_VAL, 1'b1, KIND_INT, 1'b0, 1, 1));
        directed_rows.push_back(make_row(MAX_VAL, MIN_VAL, 1'b1, KIND_RATIO, 1'b1,
                                         MAX_VAL, MIN_VAL));
        directed_rows.push_back(make_row(NEG_ONE, NEG_ONE, 1'b1, KIND_INT, 1'b0, 1, 1));
        directed_rows.push_back(make_row(ONE, ONE, 1'b1, KIND_INT, 1'b0, 1, 1));
        directed_rows.push_back(make_row(6, -4, 1'b0, KIND_ZERO, 1'b0, 0, 0));
        directed_rows.push_back(make_row(-12, -18, 1'b0, KIND_ZERO, 1'b0, 0, 0));
        directed_rows.push_back(make_row(3, 7, 1'b0, KIND_ZERO, 1'b0, 0, 0));
        directed_rows.push_back(make_row(32'h4000_0000, 32'h7fff_fffe, 1'b0, KIND_ZERO, 1'b0,
                                         0, 0));
        // consecutive Fibonacci numbers: longest remainder chain
        directed_rows.push_back(make_row(1836311903, 1134903170, 1'b0, KIND_ZERO, 1'b0, 0, 0));
        directed_rows.push_back(make_row(32'h1234_5678, 32'hf530_eca9, 1'b0, KIND_ZERO, 1'b0,
                                         0, 0));

        // Reset asserted from the start, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer_fraction(directed_rows[i].num, directed_rows[i].den,
                           directed_rows[i].fixed_exp, directed_rows[i].answer, steady_left);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick_operands(num, den);
            offer_fraction(num, den, 1'b0, unused, steady_left);
        end
        in_valid = 1'b0;

        // Drain, then watch for stray results
        while (reduced_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_rational_fraction_reducer passed");
        else
            $display("tb_rational_fraction_reducer failed");
        $finish;
    end

endmodule
